@@ design/fbc_pkg.sv @@
// Shared types and constants for the frustum box cull block.
`default_nettype none

package fbc_pkg;

  localparam int unsigned NUM_PLANE_REGS = 6;
  localparam int unsigned PLANE_COUNT    = 6;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned TAG_W          = 16;
  localparam int unsigned NORMAL_W       = 15;
  localparam int unsigned PDIST_W        = 19;
  localparam int unsigned FRAC_W         = 13;
  localparam int unsigned CFG_DATA_W     = 64;
  localparam int unsigned CFG_IDX_W      = $clog2(NUM_PLANE_REGS);
  localparam int unsigned PROD_W         = NORMAL_W + COORD_W;
  localparam int unsigned DTERM_W        = PDIST_W + FRAC_W;
  localparam int unsigned SUM_W          = PROD_W + 3;

  typedef struct packed {
    logic signed [PDIST_W-1:0]  pdist;
    logic signed [NORMAL_W-1:0] nz;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec3_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } fbc_adv_t;

endpackage

`default_nettype wire

@@ design/fbc_if.sv @@
// Valid/ready channel interfaces for boxes, results and plane writes.
`default_nettype none

interface fbc_box_if import fbc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TAG_W-1:0]          box_tag;
  logic signed [COORD_W-1:0] min_x;
  logic signed [COORD_W-1:0] min_y;
  logic signed [COORD_W-1:0] min_z;
  logic signed [COORD_W-1:0] max_x;
  logic signed [COORD_W-1:0] max_y;
  logic signed [COORD_W-1:0] max_z;

  modport source (output valid, box_tag, min_x, min_y, min_z, max_x, max_y, max_z,
                  input ready);
  modport sink (input valid, box_tag, min_x, min_y, min_z, max_x, max_y, max_z,
                output ready);
endinterface

interface fbc_res_if import fbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] result_tag;
  logic             visible;

  modport source (output valid, result_tag, visible, input ready);
  modport sink (input valid, result_tag, visible, output ready);
endinterface

interface fbc_cfg_if import fbc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/frustum_box_cull.sv @@
// Frustum culling of axis-aligned boxes against configured planes.
// Stages: box registered in stage 1, products in stage 2, plane sum signs in stage 3; AND at output.
// Throughput: one box per cycle; the three-stage pipeline collapses bubbles
// and holds every stage on output stall.
// Reset: asynchronous, active low; clears valid bits and all planes to zero
// (all boxes visible). Plane writes are taken every cycle.
`default_nettype none

module frustum_box_cull import fbc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fbc_box_if.sink    box_i,
  fbc_res_if.source  res_o,
  fbc_cfg_if.sink    cfg_i
);

  plane_t                 plane_q [NUM_PLANE_REGS];
  logic                   v1_q, v2_q, v3_q;
  logic                   s1_ready, s2_ready, s3_ready;
  logic [TAG_W-1:0]       tag1_q, tag2_q, tag3_q;
  vec3_t                  lo_q, hi_q;
  logic [PLANE_COUNT-1:0] pass;
  fbc_adv_t               adv;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANE_REGS; i++) begin
        plane_q[i] <= '0;
      end
    end else if (cfg_i.valid && (cfg_i.index < CFG_IDX_W'(NUM_PLANE_REGS))) begin
      plane_q[cfg_i.index] <= plane_t'(cfg_i.data);
    end
  end

  assign s3_ready = !v3_q || res_o.ready;
  assign s2_ready = !v2_q || s3_ready;
  assign s1_ready = !v1_q || s2_ready;

  // product registers are stage 2, pass registers stage 3
  assign adv.s1_en = s2_ready;
  assign adv.s2_en = s3_ready;

  assign box_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s1_ready) v1_q <= box_i.valid;
      if (s2_ready) v2_q <= v1_q;
      if (s3_ready) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      tag1_q <= box_i.box_tag;
      lo_q   <= '{z: box_i.min_z, y: box_i.min_y, x: box_i.min_x};
      hi_q   <= '{z: box_i.max_z, y: box_i.max_y, x: box_i.max_x};
    end
    if (s2_ready) begin
      tag2_q <= tag1_q;
    end
    if (s3_ready) begin
      tag3_q <= tag2_q;
    end
  end

  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
    fbc_plane_test u_plane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .plane_i (plane_q[g]),
      .lo_i    (lo_q),
      .hi_i    (hi_q),
      .pass_o  (pass[g])
    );
  end

  assign res_o.valid      = v3_q;
  assign res_o.result_tag = tag3_q;
  assign res_o.visible    = &pass;

  // an accepted box always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_i.valid && box_i.ready |=> v1_q)
    else $error("accepted box lost at stage 1");

  // a stalled first stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !s2_ready |=> v1_q && $stable(tag1_q))
    else $error("stage 1 item changed under stall");

  // output drains to empty when nothing is behind it
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.ready && !v2_q |=> !res_o.valid)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire

@@ design/fbc_plane_test.sv @@
// One plane lane: positive vertex select and products, then signed distance sign.
`default_nettype none

module fbc_plane_test import fbc_pkg::*; (
  input  wire logic     clk_i,
  input  fbc_adv_t      adv_i,
  input  plane_t        plane_i,
  input  vec3_t         lo_i,
  input  vec3_t         hi_i,
  output logic          pass_o
);

  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [PROD_W-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [DTERM_W-1:0] d_term;
  logic signed [SUM_W-1:0]   sum;
  logic                      pass_d, pass_q;

  // negative normal component takes the minimum corner
  assign px = plane_i.nx[NORMAL_W-1] ? lo_i.x : hi_i.x;
  assign py = plane_i.ny[NORMAL_W-1] ? lo_i.y : hi_i.y;
  assign pz = plane_i.nz[NORMAL_W-1] ? lo_i.z : hi_i.z;

  assign prod_x_d = plane_i.nx * px;
  assign prod_y_d = plane_i.ny * py;
  assign prod_z_d = plane_i.nz * pz;

  always_ff @(posedge clk_i) begin
    if (adv_i.s1_en) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
    end
  end

  assign d_term = {plane_i.pdist, {FRAC_W{1'b0}}};
  assign sum    = prod_x_q + prod_y_q + prod_z_q + d_term;
  assign pass_d = ~sum[SUM_W-1];

  always_ff @(posedge clk_i) begin
    if (adv_i.s2_en) begin
      pass_q <= pass_d;
    end
  end

  assign pass_o = pass_q;

endmodule

`default_nettype wire
